// ===== rtl/fss_pkg.sv =====
// shared types, constants and register codes for the folded substring search
package fss_pkg;

    localparam int NEEDLE_MAX = 16;
    localparam int UNIT_W     = 16;
    localparam int POS_W      = 16;
    localparam int LEN_W      = 5;
    localparam int IDX_W      = $clog2(NEEDLE_MAX);
    localparam int WORD_W     = 64;
    localparam int WORDS      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [POS_W-1:0]  NAME_MAX      = 16'hFFFF;
    localparam logic [UNIT_W-1:0] ASCII_UPPER_A = 16'h0041;
    localparam logic [UNIT_W-1:0] ASCII_UPPER_Z = 16'h005A;
    localparam logic [UNIT_W-1:0] CASE_OFFSET   = 16'h0020;

    typedef logic [UNIT_W-1:0] unit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LENGTH = 3'd0,
        CFG_NEEDLE_UNITS_A = 3'd1,
        CFG_NEEDLE_UNITS_B = 3'd2,
        CFG_NEEDLE_UNITS_C = 3'd3,
        CFG_NEEDLE_UNITS_D = 3'd4
    } cfg_reg_e;

    // needle as seen by the datapath, length already clamped
    typedef struct packed {
        logic [LEN_W-1:0]                  length;
        logic [NEEDLE_MAX-1:0][UNIT_W-1:0] units;
    } needle_cfg_t;

    // one input beat held in the input register
    typedef struct packed {
        unit_t unit;
        logic  present;
        logic  closing;
    } item_t;

endpackage

// ===== rtl/fss_cfg_regs.sv =====
// needle configuration registers and length clamp
module fss_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fss_pkg::WORD_W-1:0]     cfg_data,
    output fss_pkg::needle_cfg_t           needle
);

    logic [fss_pkg::LEN_W-1:0]                          length_reg;
    logic [fss_pkg::WORDS-1:0][fss_pkg::WORD_W-1:0]     words_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            words_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (fss_pkg::cfg_reg_e'(cfg_index))
                fss_pkg::CFG_NEEDLE_LENGTH:  length_reg   <= cfg_data[fss_pkg::LEN_W-1:0];
                fss_pkg::CFG_NEEDLE_UNITS_A: words_reg[0] <= cfg_data;
                fss_pkg::CFG_NEEDLE_UNITS_B: words_reg[1] <= cfg_data;
                fss_pkg::CFG_NEEDLE_UNITS_C: words_reg[2] <= cfg_data;
                fss_pkg::CFG_NEEDLE_UNITS_D: words_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (length_reg > fss_pkg::LEN_W'(fss_pkg::NEEDLE_MAX))
            needle.length = fss_pkg::LEN_W'(fss_pkg::NEEDLE_MAX);
        else
            needle.length = length_reg;
        needle.units = words_reg;
    end

endmodule

// ===== rtl/fss_match_unit.sv =====
// ascii case fold and per-position needle compare
module fss_match_unit (
    input  fss_pkg::unit_t                   unit,
    input  fss_pkg::needle_cfg_t             needle,
    output logic [fss_pkg::NEEDLE_MAX-1:0]   eq
);

    fss_pkg::unit_t folded;

    always_comb
    begin
        if (unit >= fss_pkg::ASCII_UPPER_A && unit <= fss_pkg::ASCII_UPPER_Z)
            folded = unit + fss_pkg::CASE_OFFSET;
        else
            folded = unit;
    end

    always_comb
    begin
        for (int k = 0; k < fss_pkg::NEEDLE_MAX; k++)
        begin
            eq[k] = (fss_pkg::LEN_W'(k) < needle.length) && (needle.units[k] == folded);
        end
    end

endmodule

// ===== rtl/fss_search.sv =====
// shift-and state per name and the result register
module fss_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  fss_pkg::item_t                    item,
    input  logic [fss_pkg::LEN_W-1:0]         length,
    input  logic [fss_pkg::NEEDLE_MAX-1:0]    eq,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              match_found,
    output logic [fss_pkg::POS_W-1:0]         match_start
);

    logic [fss_pkg::NEEDLE_MAX-1:0] partial_reg, partial_next;
    logic [fss_pkg::POS_W-1:0]      count_reg, count_next;
    logic                           seen_reg, seen_next;
    logic [fss_pkg::POS_W-1:0]      first_reg, first_next;
    logic                           out_valid_reg;
    logic                           found_reg, found_next;
    logic [fss_pkg::POS_W-1:0]      start_reg, start_next;

    logic [fss_pkg::NEEDLE_MAX-1:0] partial_upd;
    logic [fss_pkg::IDX_W-1:0]      last_idx;
    logic [fss_pkg::POS_W-1:0]      span;
    logic                           hit;
    logic                           empty_needle;

    always_comb
    begin
        empty_needle = (length == '0);
        last_idx     = fss_pkg::IDX_W'(length - fss_pkg::LEN_W'(1));
        span         = fss_pkg::POS_W'(last_idx);

        if (item.present)
            partial_upd = ((partial_reg << 1) | fss_pkg::NEEDLE_MAX'(1)) & eq;
        else
            partial_upd = partial_reg;

        hit = item.present && !empty_needle && partial_upd[last_idx] && !seen_reg;

        seen_next  = seen_reg | hit;
        first_next = first_reg;
        if (hit)
        begin
            // first unit of the occurrence that ends here
            if (count_reg >= span)
                first_next = count_reg - span;
            else
                first_next = '0;
        end

        count_next = count_reg;
        if (item.present && count_reg != fss_pkg::NAME_MAX)
            count_next = count_reg + fss_pkg::POS_W'(1);

        partial_next = partial_upd;

        if (empty_needle)
        begin
            found_next = 1'b1;
            start_next = '0;
        end
        else
        begin
            found_next = seen_next;
            start_next = seen_next ? first_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            first_reg   <= '0;
        end
        else if (advance)
        begin
            if (item.closing)
            begin
                partial_reg <= '0;
                count_reg   <= '0;
                seen_reg    <= 1'b0;
                first_reg   <= '0;
            end
            else
            begin
                partial_reg <= partial_next;
                count_reg   <= count_next;
                seen_reg    <= seen_next;
                first_reg   <= first_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && item.closing)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item.closing)
        begin
            found_reg <= found_next;
            start_reg <= start_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_found = found_reg;
    assign match_start = start_reg;

endmodule

// ===== rtl/folded_substring_search_core.sv =====
// top level: input register, needle registers, shift-and search and result beat
//
//   channel  direction  signals
//   in       sink       in_valid in_ready text_unit unit_present end_of_name
//   cfg      sink       cfg_valid cfg_ready cfg_index cfg_data
//   out      source     out_valid out_ready match_found match_start final_flag
//
// one input beat per cycle, unless a closing beat waits for the result register to free up;
// a closing beat passes the input register, then loads the result register; the combinational
// fold, compare and shift-and update between input and result registers set the rate
// reset clears the needle, the per-name state and both valid flags; cfg is always ready
// a held result stalls only a closing beat; other beats keep flowing behind it
module folded_substring_search_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [15:0]                        text_unit,
    input  logic                               unit_present,
    input  logic                               end_of_name,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fss_pkg::WORD_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               match_found,
    output logic [15:0]                        match_start,
    output logic                               final_flag
);

    fss_pkg::needle_cfg_t            needle;
    fss_pkg::item_t                  item_reg;
    logic                            item_valid_reg;
    logic                            advance;
    logic                            out_free;
    logic [fss_pkg::NEEDLE_MAX-1:0]  eq;

    assign cfg_ready = 1'b1;

    fss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .needle    (needle)
    );

    // result register free now or after this edge
    assign out_free = !out_valid || out_ready;
    assign advance  = item_valid_reg && (!item_reg.closing || out_free);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.unit    <= text_unit;
            item_reg.present <= unit_present;
            item_reg.closing <= end_of_name;
        end
    end

    fss_match_unit u_match (
        .unit   (item_reg.unit),
        .needle (needle),
        .eq     (eq)
    );

    fss_search u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .length      (needle.length),
        .eq          (eq),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .match_found (match_found),
        .match_start (match_start)
    );

    assign final_flag = 1'b1;

endmodule

// ===== verif/tb_folded_substring_search_core.sv =====
// self-checking testbench for folded_substring_search_core with a built-in needle search predictor
module tb_folded_substring_search_core;
    import fss_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int CALM_TAIL    = 200;
    localparam int RAND_ITEMS   = 1425;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CLOSES  = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT        = 2_500_000;

    typedef enum logic [1:0] {
        OP_BEAT,
        OP_WRITE,
        OP_DRAIN
    } op_kind_e;

    typedef struct {
        op_kind_e          kind;
        item_t             beat;
        cfg_reg_e          addr;
        logic [WORD_W-1:0] data;
    } op_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
    } verdict_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [15:0]          text_unit    = '0;
    logic                 unit_present = 1'b0;
    logic                 end_of_name  = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [WORD_W-1:0]    cfg_data     = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 match_found;
    logic [15:0]          match_start;
    logic                 final_flag;

    // predictor copy of the needle and the per-name search state
    logic [LEN_W-1:0]      nd_len;
    logic [WORD_W-1:0]     nd_words [WORDS];
    logic [NEEDLE_MAX-1:0] hit_vec;
    logic [POS_W-1:0]      name_pos;
    logic                  hit_seen;
    logic [POS_W-1:0]      hit_start;

    verdict_t verdict_q [$];
    op_t      op_q [$];
    unit_t    staged_units [NEEDLE_MAX];
    unit_t    name_buf [$];

    op_t      cur_op;
    verdict_t want;
    logic     drive_in;
    logic     drive_cfg;
    logic     calm = 1'b0;
    int       errors       = 0;
    int       results_seen = 0;
    int       quiet        = 0;
    int       gap_left     = 0;
    int       rx_stall     = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;
    int       rand_count   = 0;
    int       cycle_count  = 0;

    folded_substring_search_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_unit    (text_unit),
        .unit_present (unit_present),
        .end_of_name  (end_of_name),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_found  (match_found),
        .match_start  (match_start),
        .final_flag   (final_flag)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic clear_name_state();
        hit_vec   = '0;
        name_pos  = '0;
        hit_seen  = 1'b0;
        hit_start = '0;
    endtask

    // fold one beat, advance the shift-and vector, queue a verdict on a closing beat
    task automatic track_beat(input item_t b);
        unit_t                 u;
        logic [NEEDLE_MAX-1:0] eq;
        int                    len;
        verdict_t              v;
        len = (nd_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(nd_len);
        if (b.present)
        begin
            u = b.unit;
            if (u >= ASCII_UPPER_A && u <= ASCII_UPPER_Z)
                u = u + CASE_OFFSET;
            eq = '0;
            for (int k = 0; k < len; k++)
                eq[k] = (nd_words[k / 4][(k % 4) * UNIT_W +: UNIT_W] == u);
            hit_vec = {hit_vec[NEEDLE_MAX-2:0], 1'b1} & eq;
            if (len > 0 && hit_vec[len-1] && !hit_seen)
            begin
                hit_seen  = 1'b1;
                hit_start = (int'(name_pos) >= len - 1) ? name_pos - POS_W'(len - 1) : '0;
            end
            if (name_pos != NAME_MAX)
                name_pos++;
        end
        if (b.closing)
        begin
            v.found = (len == 0) ? 1'b1 : hit_seen;
            v.start = (len == 0 || !hit_seen) ? '0 : hit_start;
            verdict_q = {verdict_q, v};
            clear_name_state();
        end
    endtask

    task automatic take_write(input cfg_reg_e addr, input logic [WORD_W-1:0] data);
        if (addr == CFG_NEEDLE_LENGTH)
            nd_len = data[LEN_W-1:0];
        else
            nd_words[int'(addr) - 1] = data;
    endtask

    task automatic push_beat(input unit_t unit, input logic present, input logic closing);
        op_t op;
        op.kind         = OP_BEAT;
        op.beat.unit    = unit;
        op.beat.present = present;
        op.beat.closing = closing;
        op.addr         = CFG_NEEDLE_LENGTH;
        op.data         = '0;
        op_q = {op_q, op};
    endtask

    task automatic push_write(input cfg_reg_e addr, input logic [WORD_W-1:0] data);
        op_t op;
        op.kind = OP_WRITE;
        op.beat = '0;
        op.addr = addr;
        op.data = data;
        op_q = {op_q, op};
    endtask

    task automatic push_drain();
        op_t op;
        op.kind = OP_DRAIN;
        op.beat = '0;
        op.addr = CFG_NEEDLE_LENGTH;
        op.data = '0;
        op_q = {op_q, op};
    endtask

    // closing beats queued ahead of the next drain point
    function automatic int closes_ahead();
        int n;
        n = 0;
        foreach (op_q[i])
        begin
            if (op_q[i].kind == OP_DRAIN)
                break;
            if (op_q[i].kind == OP_BEAT && op_q[i].beat.closing)
                n++;
        end
        return n;
    endfunction

    // wait for an idle block, then write the length and all four unit words
    task automatic load_needle(input int len);
        logic [WORD_W-1:0] word;
        push_drain();
        push_write(CFG_NEEDLE_LENGTH, WORD_W'(len));
        for (int w = 0; w < WORDS; w++)
        begin
            for (int j = 0; j < 4; j++)
                word[j * UNIT_W +: UNIT_W] = staged_units[w * 4 + j];
            push_write(cfg_reg_e'(w + 1), word);
        end
    endtask

    function automatic unit_t pick_needle_unit();
        case ($urandom_range(0, 9))
            0:       return unit_t'($urandom);
            1:       return 16'h00E0 + unit_t'($urandom_range(0, 3));
            default: return 16'h0061 + unit_t'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic unit_t pick_text_unit();
        unit_t u;
        if ($urandom_range(0, 7) == 0)
            return unit_t'($urandom);
        u = 16'h0061 + unit_t'($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 1)
            u = u - CASE_OFFSET;
        return u;
    endfunction

    task automatic stage_random();
        foreach (staged_units[k])
            staged_units[k] = pick_needle_unit();
    endtask

    // lower-case needle units go in with random case so the fold is exercised
    task automatic embed_needle(input int count);
        unit_t u;
        for (int k = 0; k < count; k++)
        begin
            u = staged_units[k];
            if (u >= 16'h0061 && u <= 16'h007A && $urandom_range(0, 1) == 1)
                u = u - CASE_OFFSET;
            name_buf = {name_buf, u};
        end
    endtask

    // send name_buf as one name, with idle beats sprinkled in and either close form
    task automatic emit_name();
        bit split;
        split = (name_buf.size() == 0) || ($urandom_range(0, 2) == 0);
        foreach (name_buf[i])
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_beat(unit_t'($urandom), 1'b0, 1'b0);
                rand_count++;
            end
            push_beat(name_buf[i], 1'b1, !split && i == name_buf.size() - 1);
        end
        if (split)
            push_beat(unit_t'($urandom), 1'b0, 1'b1);
        rand_count += name_buf.size() + int'(split);
    endtask

    // input driver: beats and register writes come from op_q in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            quiet     = 0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_beat(cur_op.beat);
            if (cfg_valid && cfg_ready)
                take_write(cur_op.addr, cur_op.data);
            if (verdict_q.size() == 0 && !in_valid && !cfg_valid)
                quiet++;
            else
                quiet = 0;
            calm <= (op_q.size() < CALM_TAIL);
            if (!((in_valid && !in_ready) || (cfg_valid && !cfg_ready)))
            begin
                drive_in  = 1'b0;
                drive_cfg = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (op_q.size() > 0)
                begin
                    case (op_q[0].kind)
                        OP_DRAIN:
                        begin
                            if (quiet >= DRAIN_CYCLES)
                                void'(op_q.pop_front());
                        end
                        OP_BEAT:
                        begin
                            cur_op = op_q.pop_front();
                            drive_in = 1'b1;
                            text_unit    <= cur_op.beat.unit;
                            unit_present <= cur_op.beat.present;
                            end_of_name  <= cur_op.beat.closing;
                            if (!calm && $urandom_range(0, 7) == 0)
                                gap_left = $urandom_range(1, 8);
                        end
                        default:
                        begin
                            cur_op = op_q.pop_front();
                            drive_cfg = 1'b1;
                            cfg_index <= cur_op.addr;
                            cfg_data  <= cur_op.data;
                        end
                    endcase
                end
                in_valid  <= drive_in;
                cfg_valid <= drive_cfg;
            end
        end
    end

    // result side: compare each beat, then choose out_ready for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_stall  = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat expected none, actual match_found %0b",
                             $time, match_found);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    results_seen++;
                    if (match_found !== want.found)
                    begin
                        errors++;
                        $display("%0t: match_found expected %0b actual %0b",
                                 $time, want.found, match_found);
                    end
                    if (match_start !== want.start)
                    begin
                        errors++;
                        $display("%0t: match_start expected %0d actual %0d",
                                 $time, want.start, match_start);
                    end
                    if (final_flag !== 1'b1)
                    begin
                        errors++;
                        $display("%0t: final_flag expected 1 actual %0b", $time, final_flag);
                    end
                end
            end
            // one long hold-off lets the block fill up and push back on its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER && closes_ahead() >= HOLD_CLOSES)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rx_stall = $urandom_range(1, 8) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("folded_substring_search_core regression: fail");
        $finish;
    end

    initial
    begin
        int nlen;
        int eff;
        int cut;
        int kind;
        int phase;
        int phase_start;

        nd_len = '0;
        foreach (nd_words[w])
            nd_words[w] = '0;
        clear_name_state();

        // empty needle straight after reset: any name matches at 0, the empty one too
        push_beat(16'h0058, 1'b1, 1'b1);
        push_beat(16'h1234, 1'b0, 1'b1);

        stage_random();
        staged_units[0] = 16'h0061;
        staged_units[1] = 16'h0062;
        load_needle(2);
        // upper case folded, unit carried on the closing beat
        push_beat(16'h0078, 1'b1, 1'b0);
        push_beat(16'h0041, 1'b1, 1'b0);
        push_beat(16'h0042, 1'b1, 1'b1);
        // idle beat inside a name, close without a unit
        push_beat(16'h0061, 1'b1, 1'b0);
        push_beat(16'hFFFF, 1'b0, 1'b0);
        push_beat(16'h0042, 1'b1, 1'b0);
        push_beat(16'h0000, 1'b0, 1'b1);
        // name shorter than the needle, then the empty name
        push_beat(16'h0041, 1'b1, 1'b1);
        push_beat(16'h0000, 1'b0, 1'b1);
        // just outside the folded range, and non-ascii look-alikes
        push_beat(16'h0040, 1'b1, 1'b0);
        push_beat(16'h005B, 1'b1, 1'b0);
        push_beat(16'h00C2, 1'b1, 1'b0);
        push_beat(16'hFFFF, 1'b1, 1'b0);
        push_beat(16'h0000, 1'b1, 1'b1);
        // needle rewritten in the middle of a name, partial match carried over
        push_beat(16'h0061, 1'b1, 1'b0);
        push_drain();
        push_write(CFG_NEEDLE_UNITS_A, 64'h0000_0000_0063_0061);
        push_beat(16'h0043, 1'b1, 1'b1);
        // non-ascii units compare exactly
        staged_units[0] = 16'h00E9;
        load_needle(1);
        push_beat(16'h00C9, 1'b1, 1'b1);
        push_beat(16'h00E9, 1'b1, 1'b1);

        phase = 0;
        while (rand_count < RAND_ITEMS)
        begin
            stage_random();
            case (phase)
                0:       nlen = NEEDLE_MAX;
                1:       nlen = 31;
                2:       nlen = 0;
                3:       nlen = 1;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       nlen = 0;
                        1:       nlen = NEEDLE_MAX;
                        2:       nlen = $urandom_range(17, 31);
                        default: nlen = $urandom_range(2, 8);
                    endcase
                end
            endcase
            load_needle(nlen);
            eff = (nlen > NEEDLE_MAX) ? NEEDLE_MAX : nlen;
            phase_start = rand_count;
            while (rand_count - phase_start < PHASE_ITEMS && rand_count < RAND_ITEMS)
            begin
                name_buf.delete();
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    repeat ($urandom_range(0, 6))
                        name_buf = {name_buf, unit_t'($urandom)};
                end
                else
                begin
                    repeat ($urandom_range(0, 8))
                        name_buf = {name_buf, pick_text_unit()};
                    // broken sequences stop one or more units short of the needle
                    cut = (kind == 1 && eff > 0) ? $urandom_range(0, eff - 1) : eff;
                    embed_needle(cut);
                    if (kind == 2)
                        embed_needle(eff);
                    repeat ($urandom_range(0, 6))
                        name_buf = {name_buf, pick_text_unit()};
                end
                emit_name();
            end
            phase++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_q.size() != 0 || in_valid || cfg_valid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("folded_substring_search_core regression: pass");
        else
            $display("folded_substring_search_core regression: fail");
        $finish;
    end

endmodule

// ===== folded_substring_search_core.f =====
rtl/fss_pkg.sv
rtl/fss_cfg_regs.sv
rtl/fss_match_unit.sv
rtl/fss_search.sv
rtl/folded_substring_search_core.sv
verif/tb_folded_substring_search_core.sv
